>>> hdl/iaac_pkg.sv
// Shared types and constants for the intrusion alarm and access controller.
`timescale 1ns / 1ps
package iaac_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 48;

  localparam logic [CfgIdxW-1:0] RegAuthUid     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAlarmDur    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegUnlockDur   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMotionCool  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBlinkIntvl  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegToneIntvl   = 3'd5;

  localparam logic [31:0] AuthUidRst    = 32'hDEAD_BEEF;
  localparam logic [15:0] AlarmDurRst   = 16'd10000;
  localparam logic [15:0] UnlockDurRst  = 16'd3000;
  localparam logic [15:0] MotionCoolRst = 16'd2000;
  localparam logic [15:0] BlinkIntvlRst = 16'd300;
  localparam logic [15:0] ToneIntvlRst  = 16'd300;

  typedef struct packed {
    logic [31:0] authorised_uid;
    logic [15:0] alarm_duration_ms;
    logic [15:0] unlock_duration_ms;
    logic [15:0] motion_cooldown_ms;
    logic [15:0] blink_interval_ms;
    logic [15:0] tone_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic        reset_cmd;
    logic [31:0] card_uid;
    logic        card_tap;
    logic        motion;
  } item_t;

  typedef struct packed {
    logic [15:0] grants;
    logic [15:0] intrusions;
    logic        access_event;
    logic        alarm_cleared;
    logic        alarm_raised;
    logic        green_lamp;
    logic        door_unlocked;
    logic        siren_high_tone;
    logic        siren_on;
    logic        red_led;
    logic        alarm_on;
  } result_t;

endpackage

>>> hdl/intrusion_alarm_access_controller_top.sv
// Top level: input register, tick logic, result register and config port.
`timescale 1ns / 1ps
// An input item is held in the input register and its result in the result register on the master side.
// Throughput: one item per cycle while m_axis_tready is high; the whole tick is one pass of logic between
// the input register and the result register, and a new item can enter the input register while a
// finished result waits for tready only if the input register is empty.
// Reset: rst_ni is asynchronous, active low; it empties both registers, zeroes
// timers, flags and counters (the siren phase starts high) and loads defaults.
module intrusion_alarm_access_controller_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input item stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: motion[0], card_tap[1], card_uid[33:2], reset_cmd[34], zero[39:35]
  input  logic [iaac_pkg::InDataW-1:0]  s_axis_tdata,
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: alarm_on[0], red_led[1], siren_on[2], siren_high_tone[3],
  // door_unlocked[4], green_lamp[5], alarm_raised[6], alarm_cleared[7],
  // access_event[8], intrusions[24:9], grants[40:25], zero[47:41]
  output logic [iaac_pkg::OutDataW-1:0] m_axis_tdata,
  // Configuration writes.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [iaac_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  localparam int unsigned ItemW = $bits(iaac_pkg::item_t);
  localparam int unsigned ResW  = $bits(iaac_pkg::result_t);

  iaac_pkg::cfg_t    cfg;
  iaac_pkg::item_t   item_q;
  iaac_pkg::result_t res;
  iaac_pkg::result_t res_q;
  logic              in_vld_q;
  logic              out_vld_q;
  logic              step;

  // Register file takes a write every cycle.
  assign cfg_ready_o = 1'b1;

  iaac_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // Advance the held item when the result register is free or being drained.
  assign step          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  // Payload holds until the next transfer; no reset needed.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= s_axis_tdata[ItemW-1:0];
    end
  end

  iaac_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cfg_i  (cfg),
    .item_i (item_q),
    .res_o  (res)
  );

  // Result register: load on a step, drop the valid once the result is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(iaac_pkg::OutDataW - ResW){1'b0}}, res_q};

endmodule

>>> hdl/iaac_cfg_regs.sv
// Configuration register file with reset defaults.
`timescale 1ns / 1ps
module iaac_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [iaac_pkg::CfgIdxW-1:0]  wr_idx_i,
  input  logic [31:0]                   wr_data_i,
  output iaac_pkg::cfg_t                cfg_o
);

  iaac_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_idx_i)
        iaac_pkg::RegAuthUid:    cfg_d.authorised_uid     = wr_data_i;
        iaac_pkg::RegAlarmDur:   cfg_d.alarm_duration_ms  = wr_data_i[15:0];
        iaac_pkg::RegUnlockDur:  cfg_d.unlock_duration_ms = wr_data_i[15:0];
        iaac_pkg::RegMotionCool: cfg_d.motion_cooldown_ms = wr_data_i[15:0];
        iaac_pkg::RegBlinkIntvl: cfg_d.blink_interval_ms  = wr_data_i[15:0];
        iaac_pkg::RegToneIntvl:  cfg_d.tone_interval_ms   = wr_data_i[15:0];
        default: ;  // unused indexes drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.authorised_uid     <= iaac_pkg::AuthUidRst;
      cfg_q.alarm_duration_ms  <= iaac_pkg::AlarmDurRst;
      cfg_q.unlock_duration_ms <= iaac_pkg::UnlockDurRst;
      cfg_q.motion_cooldown_ms <= iaac_pkg::MotionCoolRst;
      cfg_q.blink_interval_ms  <= iaac_pkg::BlinkIntvlRst;
      cfg_q.tone_interval_ms   <= iaac_pkg::ToneIntvlRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/iaac_core.sv
// Per-tick controller state and next-state logic for one item.
`timescale 1ns / 1ps
module iaac_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  iaac_pkg::cfg_t    cfg_i,
  input  iaac_pkg::item_t   item_i,
  output iaac_pkg::result_t res_o
);

  logic [31:0] now_q, now_d;
  logic [31:0] motion_t_q, motion_t_d;
  logic [31:0] alarm_t_q, alarm_t_d;
  logic [31:0] blink_t_q, blink_t_d;
  logic [31:0] tone_t_q, tone_t_d;
  logic [31:0] unlock_t_q, unlock_t_d;
  logic        alarm_q, alarm_d;
  logic        access_q, access_d;
  logic        timing_q, timing_d;
  logic        blink_q, blink_d;
  logic        siren_q, siren_d;
  logic        high_q, high_d;
  logic        door_q, door_d;
  logic        green_q, green_d;
  logic        red_q, red_d;
  logic [15:0] intr_q, intr_d;
  logic [15:0] grant_q, grant_d;

  logic raised, cleared, granted;
  logic alarm_exp, blink_due, tone_due, unlock_exp, motion_ok, uid_match, do_raise;

  // Elapsed-time tests, all in wrapping 32-bit arithmetic.
  assign alarm_exp  = (now_q - alarm_t_q)  >= {16'd0, cfg_i.alarm_duration_ms};
  assign blink_due  = (now_q - blink_t_q)  >= {16'd0, cfg_i.blink_interval_ms};
  assign tone_due   = (now_q - tone_t_q)   >= {16'd0, cfg_i.tone_interval_ms};
  assign unlock_exp = (now_q - unlock_t_q) >= {16'd0, cfg_i.unlock_duration_ms};
  assign motion_ok  = item_i.motion &&
                      ((now_q - motion_t_q) >= {16'd0, cfg_i.motion_cooldown_ms});
  assign uid_match  = item_i.card_uid == cfg_i.authorised_uid;

  always_comb begin
    now_d      = now_q + 32'd1;
    motion_t_d = motion_t_q;
    alarm_t_d  = alarm_t_q;
    blink_t_d  = blink_t_q;
    tone_t_d   = tone_t_q;
    unlock_t_d = unlock_t_q;
    alarm_d    = alarm_q;
    access_d   = access_q;
    timing_d   = timing_q;
    blink_d    = blink_q;
    siren_d    = siren_q;
    high_d     = high_q;
    door_d     = door_q;
    green_d    = green_q;
    red_d      = red_q;
    intr_d     = intr_q;
    grant_d    = grant_q;
    raised     = 1'b0;
    cleared    = 1'b0;
    granted    = 1'b0;
    do_raise   = 1'b0;

    // Timed alarm expiry.
    if (alarm_d && alarm_exp) begin
      alarm_d = 1'b0;
      red_d   = 1'b0;
      siren_d = 1'b0;
      cleared = 1'b1;
    end

    // Lamp blink and siren tone while the alarm runs.
    if (alarm_d) begin
      if (blink_due) begin
        blink_t_d = now_q;
        blink_d   = ~blink_q;
        red_d     = ~blink_q;
      end
      if (siren_d && tone_due) begin
        tone_t_d = now_q;
        high_d   = ~high_q;
      end
    end

    // Unlock expiry.
    if (timing_d && unlock_exp) begin
      door_d   = 1'b0;
      green_d  = 1'b0;
      access_d = 1'b0;
      timing_d = 1'b0;
    end

    if (motion_ok) begin
      motion_t_d = now_q;
    end

    // Motion and a foreign card raise at most once per tick.
    do_raise = (motion_ok || (item_i.card_tap && !uid_match)) && !alarm_d && !access_d;
    if (do_raise) begin
      alarm_d   = 1'b1;
      alarm_t_d = now_q;
      blink_t_d = now_q;
      tone_t_d  = now_q;
      if (intr_d != 16'hFFFF) intr_d = intr_d + 16'd1;
      siren_d   = 1'b1;
      high_d    = 1'b1;
      door_d    = 1'b0;
      raised    = 1'b1;
    end

    if (item_i.card_tap && uid_match) begin
      if (alarm_d) begin
        alarm_d = 1'b0;
        red_d   = 1'b0;
        siren_d = 1'b0;
        cleared = 1'b1;
      end
      access_d   = 1'b1;
      if (grant_d != 16'hFFFF) grant_d = grant_d + 16'd1;
      timing_d   = 1'b1;
      unlock_t_d = now_q;
      green_d    = 1'b1;
      door_d     = 1'b1;
      granted    = 1'b1;
    end else if (!item_i.card_tap && item_i.reset_cmd && alarm_d) begin
      alarm_d = 1'b0;
      red_d   = 1'b0;
      siren_d = 1'b0;
      cleared = 1'b1;
    end

    res_o.alarm_on        = alarm_d;
    res_o.red_led         = red_d;
    res_o.siren_on        = siren_d;
    res_o.siren_high_tone = siren_d && high_d;
    res_o.door_unlocked   = door_d;
    res_o.green_lamp      = green_d;
    res_o.alarm_raised    = raised;
    res_o.alarm_cleared   = cleared;
    res_o.access_event    = granted;
    res_o.intrusions      = intr_d;
    res_o.grants          = grant_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q      <= '0;
      motion_t_q <= '0;
      alarm_t_q  <= '0;
      blink_t_q  <= '0;
      tone_t_q   <= '0;
      unlock_t_q <= '0;
      alarm_q    <= 1'b0;
      access_q   <= 1'b0;
      timing_q   <= 1'b0;
      blink_q    <= 1'b0;
      siren_q    <= 1'b0;
      high_q     <= 1'b1;
      door_q     <= 1'b0;
      green_q    <= 1'b0;
      red_q      <= 1'b0;
      intr_q     <= '0;
      grant_q    <= '0;
    end else if (step_i) begin
      now_q      <= now_d;
      motion_t_q <= motion_t_d;
      alarm_t_q  <= alarm_t_d;
      blink_t_q  <= blink_t_d;
      tone_t_q   <= tone_t_d;
      unlock_t_q <= unlock_t_d;
      alarm_q    <= alarm_d;
      access_q   <= access_d;
      timing_q   <= timing_d;
      blink_q    <= blink_d;
      siren_q    <= siren_d;
      high_q     <= high_d;
      door_q     <= door_d;
      green_q    <= green_d;
      red_q      <= red_d;
      intr_q     <= intr_d;
      grant_q    <= grant_d;
    end
  end

endmodule
